/* rtl/ipm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Isophote marker package
// Shared widths, register indexes, reset values and constants of the
// isophote crossing pixel marker.
// ----------------------------------------------------------------------------
package ipm_pkg;

    // Sample and register widths.
    localparam int SAMPLE_BITS    = 16;
    localparam int STEP_BITS      = 16;
    localparam int ROW_WIDTH_BITS = 13;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Default depth of the line store.
    localparam int MAX_ROW_WIDTH_DEFAULT = 4096;

    // Remainder pipeline: dividend bits retired per stage.
    localparam int REM_BITS_PER_STAGE = 4;

    // Smallest row the block handles.
    localparam int MIN_ROW_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_LOW  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_HIGH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_STEP     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOW_LEVEL     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_WIDTH      = 3'd4;

    // Register reset values.
    localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_LOW_RESET  = 16'sd0;
    localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_HIGH_RESET = 16'sd32767;
    localparam logic [STEP_BITS-1:0]          LEVEL_STEP_RESET     = 16'd256;
    localparam logic                          SHOW_LEVEL_RESET     = 1'b0;
    localparam int                            ROW_WIDTH_RESET      = 512;

    // Value given for a marked pixel when the level is not shown.
    localparam logic signed [SAMPLE_BITS-1:0] ISO_MARK = 16'sd1;

endpackage
`default_nettype wire

/* rtl/ipm_pixel_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one image sample per word.
// ----------------------------------------------------------------------------
interface ipm_pixel_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ipm_pkg::SAMPLE_BITS-1:0] pixel_value;
    logic                                   frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface
`default_nettype wire

/* rtl/ipm_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one marker result per word.
// ----------------------------------------------------------------------------
interface ipm_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ipm_pkg::SAMPLE_BITS-1:0] iso_value;
    logic                                   on_contour;

    modport source (output valid, output iso_value, output on_contour, input ready);
    modport sink   (input valid, input iso_value, input on_contour, output ready);
endinterface
`default_nettype wire

/* rtl/ipm_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ipm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ipm_pkg::CFG_INDEX_BITS-1:0]    index;
    logic [ipm_pkg::CFG_DATA_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ipm_rem_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined remainder unit
// Restoring division of an unsigned dividend by an unsigned divisor that
// retires a few dividend bits per stage. Each stage has its own valid bit and
// advances when the next stage is empty or moving. A side word travels with
// every item.
// ----------------------------------------------------------------------------
module ipm_rem_pipe #(
    parameter int DIVIDEND_BITS  = ipm_pkg::SAMPLE_BITS,
    parameter int BITS_PER_STAGE = ipm_pkg::REM_BITS_PER_STAGE,
    parameter int SIDE_BITS      = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [DIVIDEND_BITS-1:0]      in_dividend,
    input  wire logic [SIDE_BITS-1:0]          in_side,
    input  wire logic [ipm_pkg::STEP_BITS-1:0] divisor,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ipm_pkg::STEP_BITS-1:0]      out_rem,
    output logic [SIDE_BITS-1:0]               out_side
);

    localparam int STAGES   = (DIVIDEND_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_BITS = STAGES * BITS_PER_STAGE;
    localparam int RB       = ipm_pkg::STEP_BITS;

    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   en;
    logic [STAGES-1:0]   src_valid;
    logic [PAD_BITS-1:0] src_bits [STAGES];
    logic [RB-1:0]       src_rem  [STAGES];
    logic [SIDE_BITS-1:0] src_side [STAGES];
    logic [PAD_BITS-1:0] bits_reg [STAGES];
    logic [RB-1:0]       rem_reg  [STAGES];
    logic [SIDE_BITS-1:0] side_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [PAD_BITS-1:0] bits_next;
        logic [RB-1:0]       rem_next;

        if (k == 0) begin : g_first
            assign src_valid[k] = in_valid;
            assign src_bits[k]  = PAD_BITS'(in_dividend);
            assign src_rem[k]   = '0;
            assign src_side[k]  = in_side;
        end
        else begin : g_rest
            assign src_valid[k] = valid_reg[k-1];
            assign src_bits[k]  = bits_reg[k-1];
            assign src_rem[k]   = rem_reg[k-1];
            assign src_side[k]  = side_reg[k-1];
        end

        if (k == STAGES - 1) begin : g_last_en
            assign en[k] = !valid_reg[k] || out_ready;
        end
        else begin : g_mid_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end

        // Shift the stage's dividend bits one at a time into the partial
        // remainder and subtract the divisor whenever it fits.
        always_comb
        begin : step_logic
            logic [RB:0]         trial;
            logic [RB-1:0]       rem_w;
            logic [PAD_BITS-1:0] bits_w;
            rem_w  = src_rem[k];
            bits_w = src_bits[k];
            trial  = '0;
            for (int i = 0; i < BITS_PER_STAGE; i++)
            begin
                trial  = {rem_w, bits_w[PAD_BITS-1]};
                bits_w = {bits_w[PAD_BITS-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    rem_w = RB'(trial - {1'b0, divisor});
                end
                else
                begin
                    rem_w = trial[RB-1:0];
                end
            end
            rem_next  = rem_w;
            bits_next = bits_w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k] && src_valid[k])
            begin
                bits_reg[k] <= bits_next;
                rem_reg[k]  <= rem_next;
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
`default_nettype wire

/* rtl/isophote_crossing_pixel_marker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Isophote crossing pixel marker
// Marks pixels of a raster image that a contour level crosses, using the
// pixel, its right neighbour in the row above and the one above it.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and gives one result word per
// clock at full rate, while the result channel takes every word. A pixel's
// result passes two remainder pipelines (four dividend bits per stage) and
// the sort, combine and output stages. The row above lives in a single line
// store with one write and one registered read per pixel; the upper value
// comes from the previous read. A result is made for each incoming pixel
// that has a row above it and is not at the end of its row, so the first row
// of a frame and the last column of each row give nothing. The line store is
// not cleared after reset. Configuration is taken at any time, one word a
// clock, and must be written while the block is idle.
// ----------------------------------------------------------------------------
module isophote_crossing_pixel_marker #(
    parameter int MAX_ROW_WIDTH = ipm_pkg::MAX_ROW_WIDTH_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ipm_pixel_if.sink    pixel,
    ipm_cfg_if.sink      cfg,
    ipm_result_if.source result
);

    localparam int SB = ipm_pkg::SAMPLE_BITS;
    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int WW = (CW + 1 > ipm_pkg::ROW_WIDTH_BITS) ? CW + 1 : ipm_pkg::ROW_WIDTH_BITS;
    localparam int RESET_WIDTH = (ipm_pkg::ROW_WIDTH_RESET > MAX_ROW_WIDTH) ?
                                 MAX_ROW_WIDTH : ipm_pkg::ROW_WIDTH_RESET;
    localparam logic [CW-1:0] LAST_COL_RESET = CW'(RESET_WIDTH - 1);
    localparam int SIDE1_BITS = 2 * SB + 2;
    localparam int SIDE2_BITS = SB + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SB-1:0]             threshold_low_reg;
    logic signed [SB-1:0]             threshold_high_reg;
    logic [ipm_pkg::STEP_BITS-1:0]    level_step_reg;
    logic                             show_level_reg;
    logic [CW-1:0]                    last_col_reg;
    logic                             cfg_write;
    logic [WW-1:0]                    rw_ext;
    logic [WW-1:0]                    width_eff;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign rw_ext    = WW'(cfg.data[ipm_pkg::ROW_WIDTH_BITS-1:0]);

    // Out-of-range row widths are pulled into the supported range.
    always_comb
    begin
        if (rw_ext < WW'(ipm_pkg::MIN_ROW_WIDTH))
        begin
            width_eff = WW'(ipm_pkg::MIN_ROW_WIDTH);
        end
        else if (rw_ext > WW'(MAX_ROW_WIDTH))
        begin
            width_eff = WW'(MAX_ROW_WIDTH);
        end
        else
        begin
            width_eff = rw_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_low_reg  <= ipm_pkg::THRESHOLD_LOW_RESET;
            threshold_high_reg <= ipm_pkg::THRESHOLD_HIGH_RESET;
            level_step_reg     <= ipm_pkg::LEVEL_STEP_RESET;
            show_level_reg     <= ipm_pkg::SHOW_LEVEL_RESET;
            last_col_reg       <= LAST_COL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                ipm_pkg::CFG_THRESHOLD_LOW:  threshold_low_reg  <= $signed(cfg.data[SB-1:0]);
                ipm_pkg::CFG_THRESHOLD_HIGH: threshold_high_reg <= $signed(cfg.data[SB-1:0]);
                ipm_pkg::CFG_LEVEL_STEP:
                    level_step_reg <= cfg.data[ipm_pkg::STEP_BITS-1:0];
                ipm_pkg::CFG_SHOW_LEVEL:     show_level_reg     <= cfg.data[0];
                ipm_pkg::CFG_ROW_WIDTH:      last_col_reg       <= CW'(width_eff - WW'(1));
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshakes
    // ------------------------------------------------------------------
    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg, v_f_reg;
    logic en_a, en_b, en_c, en_d, en_e, en_f;
    logic div1_in_ready, div1_out_valid;
    logic div2_in_ready, div2_out_valid;

    assign en_f = !v_f_reg || result.ready;
    assign en_e = !v_e_reg || en_f;
    assign en_d = !v_d_reg || div2_in_ready;
    assign en_c = !v_c_reg || en_d;
    assign en_b = !v_b_reg || div1_in_ready;
    assign en_a = !v_a_reg || en_b;

    // ------------------------------------------------------------------
    // Column tracking and line store
    // ------------------------------------------------------------------
    logic [CW-1:0] column_index_reg, column_index_next;
    logic          row_above_valid_reg, row_above_valid_next;
    logic          accept;
    logic [CW-1:0] col_cur;
    logic [CW-1:0] col_following;
    logic          above_cur;
    logic          row_end;
    logic          eligible;

    logic signed [SB-1:0] line_mem [MAX_ROW_WIDTH];
    logic signed [SB-1:0] mem_rd_reg;

    assign pixel.ready = en_a;
    assign accept      = pixel.valid && pixel.ready;

    assign col_cur       = pixel.frame_start ? '0 : column_index_reg;
    assign above_cur     = pixel.frame_start ? 1'b0 : row_above_valid_reg;
    assign row_end       = col_cur >= last_col_reg;
    assign eligible      = above_cur && !row_end;
    assign col_following = row_end ? '0 : CW'(col_cur + CW'(1));

    assign column_index_next    = accept ? col_following : column_index_reg;
    assign row_above_valid_next = accept ? (above_cur || row_end) : row_above_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg    <= '0;
            row_above_valid_reg <= 1'b0;
        end
        else
        begin
            column_index_reg    <= column_index_next;
            row_above_valid_reg <= row_above_valid_next;
        end
    end

    // The read fetches the upper-right sample of this pixel; at a row end it
    // fetches column 0, which the next row needs as its first upper sample.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_cur] <= pixel.pixel_value;
            mem_rd_reg        <= line_mem[col_following];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: pixel, upper and upper-right samples
    // ------------------------------------------------------------------
    logic signed [SB-1:0] px_a_reg;
    logic signed [SB-1:0] top_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
        end
        else if (en_a)
        begin
            v_a_reg <= pixel.valid && eligible;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_a_reg  <= pixel.pixel_value;
            top_a_reg <= mem_rd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: sort and first dividend
    // ------------------------------------------------------------------
    logic signed [SB-1:0] hi_w, lo_w, hi_ab, lo_ab;
    logic [SB:0]          d1_w, d1_abs_w, lmh_w;
    logic [SB-1:0]        mag_b_reg;
    logic                 neg_b_reg;
    logic signed [SB-1:0] lo_b_reg;
    logic [SB:0]          lmh_b_reg;

    always_comb
    begin
        hi_ab = (top_a_reg > px_a_reg) ? top_a_reg : px_a_reg;
        lo_ab = (top_a_reg < px_a_reg) ? top_a_reg : px_a_reg;
        hi_w  = (mem_rd_reg > hi_ab) ? mem_rd_reg : hi_ab;
        lo_w  = (mem_rd_reg < lo_ab) ? mem_rd_reg : lo_ab;
    end

    assign d1_w     = {hi_w[SB-1], hi_w} - {threshold_low_reg[SB-1], threshold_low_reg};
    assign d1_abs_w = d1_w[SB] ? (~d1_w + (SB+1)'(1)) : d1_w;
    assign lmh_w    = {lo_w[SB-1], lo_w} - {hi_w[SB-1], hi_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b_reg <= 1'b0;
        end
        else if (en_b)
        begin
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && v_a_reg)
        begin
            mag_b_reg <= d1_abs_w[SB-1:0];
            neg_b_reg <= d1_w[SB];
            lo_b_reg  <= lo_w;
            lmh_b_reg <= lmh_w;
        end
    end

    // ------------------------------------------------------------------
    // First remainder: (max - low) rem step
    // ------------------------------------------------------------------
    logic [ipm_pkg::STEP_BITS-1:0] rem1;
    logic [SIDE1_BITS-1:0]         side1_out;

    ipm_rem_pipe #(
        .DIVIDEND_BITS  (SB),
        .BITS_PER_STAGE (ipm_pkg::REM_BITS_PER_STAGE),
        .SIDE_BITS      (SIDE1_BITS)
    ) u_rem_first (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v_b_reg),
        .in_ready    (div1_in_ready),
        .in_dividend (mag_b_reg),
        .in_side     ({lo_b_reg, lmh_b_reg, neg_b_reg}),
        .divisor     (level_step_reg),
        .out_valid   (div1_out_valid),
        .out_ready   (en_c),
        .out_rem     (rem1),
        .out_side    (side1_out)
    );

    // ------------------------------------------------------------------
    // Stage C: second dividend = (min - max) + signed first remainder
    // ------------------------------------------------------------------
    logic [SB:0]          rem1_ext, r1_w;
    logic [SB+1:0]        n2_w;
    logic [SB+1:0]        n2_c_reg;
    logic signed [SB-1:0] lo_c_reg;
    logic                 neg1_w;
    logic [SB:0]          lmh1_w;
    logic signed [SB-1:0] lo1_w;

    assign lo1_w    = $signed(side1_out[SIDE1_BITS-1 -: SB]);
    assign lmh1_w   = side1_out[SB+1:1];
    assign neg1_w   = side1_out[0];
    assign rem1_ext = (SB+1)'(rem1);
    assign r1_w     = neg1_w ? (~rem1_ext + (SB+1)'(1)) : rem1_ext;
    assign n2_w     = {lmh1_w[SB], lmh1_w} + {r1_w[SB], r1_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
        end
        else if (en_c)
        begin
            v_c_reg <= div1_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c && div1_out_valid)
        begin
            n2_c_reg <= n2_w;
            lo_c_reg <= lo1_w;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: magnitude of the second dividend, and a flag that the
    // magnitude reaches one step.
    // ------------------------------------------------------------------
    logic [SB+1:0]        n2_abs_w;
    logic [SB:0]          mag_d_reg;
    logic                 neg_d_reg;
    logic                 big_d_reg;
    logic signed [SB-1:0] lo_d_reg;

    assign n2_abs_w = n2_c_reg[SB+1] ? (~n2_c_reg + (SB+2)'(1)) : n2_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= 1'b0;
        end
        else if (en_d)
        begin
            v_d_reg <= v_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d && v_c_reg)
        begin
            mag_d_reg <= n2_abs_w[SB:0];
            neg_d_reg <= n2_c_reg[SB+1];
            big_d_reg <= n2_abs_w >= (SB+2)'(level_step_reg);
            lo_d_reg  <= lo_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // Second remainder
    // ------------------------------------------------------------------
    logic [ipm_pkg::STEP_BITS-1:0] rem2;
    logic [SIDE2_BITS-1:0]         side2_out;

    ipm_rem_pipe #(
        .DIVIDEND_BITS  (SB + 1),
        .BITS_PER_STAGE (ipm_pkg::REM_BITS_PER_STAGE),
        .SIDE_BITS      (SIDE2_BITS)
    ) u_rem_second (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v_d_reg),
        .in_ready    (div2_in_ready),
        .in_dividend (mag_d_reg),
        .in_side     ({lo_d_reg, neg_d_reg, big_d_reg}),
        .divisor     (level_step_reg),
        .out_valid   (div2_out_valid),
        .out_ready   (en_e),
        .out_rem     (rem2),
        .out_side    (side2_out)
    );

    // ------------------------------------------------------------------
    // Stage E: the candidate level equals min minus the second remainder.
    // ------------------------------------------------------------------
    logic [SB:0]          rem2_ext, r2_w;
    logic signed [SB-1:0] lo2_w;
    logic [SB+1:0]        level_w;
    logic signed [SB+1:0] level_e_reg;
    logic                 big_e_reg;

    assign lo2_w    = $signed(side2_out[SIDE2_BITS-1 -: SB]);
    assign rem2_ext = (SB+1)'(rem2);
    assign r2_w     = side2_out[1] ? (~rem2_ext + (SB+1)'(1)) : rem2_ext;
    assign level_w  = {{2{lo2_w[SB-1]}}, lo2_w} - {r2_w[SB], r2_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e_reg <= 1'b0;
        end
        else if (en_e)
        begin
            v_e_reg <= div2_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_e && div2_out_valid)
        begin
            level_e_reg <= $signed(level_w);
            big_e_reg   <= side2_out[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage F: range check and output register
    // ------------------------------------------------------------------
    logic signed [SB+1:0] low_ext, high_ext;
    logic                 mark_w;
    logic signed [SB-1:0] iso_w;
    logic signed [SB-1:0] iso_f_reg;
    logic                 mark_f_reg;

    assign low_ext  = $signed({{2{threshold_low_reg[SB-1]}}, threshold_low_reg});
    assign high_ext = $signed({{2{threshold_high_reg[SB-1]}}, threshold_high_reg});
    assign mark_w   = big_e_reg && (level_step_reg != '0) &&
                      (level_e_reg > low_ext) && (level_e_reg < high_ext);

    always_comb
    begin
        if (!mark_w)
        begin
            iso_w = '0;
        end
        else if (show_level_reg)
        begin
            iso_w = $signed(level_e_reg[SB-1:0]);
        end
        else
        begin
            iso_w = ipm_pkg::ISO_MARK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg <= 1'b0;
        end
        else if (en_f)
        begin
            v_f_reg <= v_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f && v_e_reg)
        begin
            iso_f_reg  <= iso_w;
            mark_f_reg <= mark_w;
        end
    end

    assign result.valid      = v_f_reg;
    assign result.iso_value  = iso_f_reg;
    assign result.on_contour = mark_f_reg;

`ifndef SYNTH
    // A frame start always restarts at column 0 of a first row.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pixel.frame_start |=> !row_above_valid_reg && column_index_reg == CW'(1))
        else $error("frame start did not restart the row tracking");

    // Pixels without both upper neighbours never enter the datapath.
    a_no_result_ineligible: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !eligible |=> !v_a_reg)
        else $error("ineligible pixel entered the pipeline");

    // An unmarked result carries zero.
    a_unmarked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.on_contour |-> result.iso_value == '0)
        else $error("unmarked result with nonzero value");

    // In mark mode a marked result carries the mark value.
    a_mark_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.on_contour && !show_level_reg |->
            result.iso_value == ipm_pkg::ISO_MARK)
        else $error("marked result with wrong value");
`endif

endmodule
`default_nettype wire
